### rtl/dtcf_pkg.sv
// Package with shared constants and types for the double to custom float converter.
package dtcf_pkg;
  localparam int unsigned AddrWidth = 3;
  localparam logic [AddrWidth-1:0] AddrExpWidth = 3'd0;
  localparam logic [AddrWidth-1:0] AddrManWidth = 3'd4;
  localparam logic [3:0] ExpWidthReset = 4'd8;
  localparam logic [5:0] ManWidthReset = 6'd23;

  typedef struct packed {
    logic [3:0] e;
    logic [5:0] m;
  } fmt_t;

  typedef struct packed {
    logic        sign;
    logic        special;
    logic        zero;
    logic [52:0] sig;
    logic [12:0] exp_top;
  } norm_t;

  typedef struct packed {
    logic        sign;
    logic        special;
    logic        zero;
    logic        subn;
    logic [12:0] exp_top;
    logic [52:0] sig;
    logic [6:0]  shift;
  } plan_t;
endpackage

### rtl/double_to_custom_float_top.sv
// Top level of the double to custom float converter with its register port.
// An accepted start passes the unpack, plan, round and pack registers before the done strobe.
// Throughput: one word per cycle; busy is always low.
// The result stays on the ports for one cycle, marked by done_o.
// Reset clears the valid bits and sets exp_width to 8 and man_width to 23.
module double_to_custom_float_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [63:0]                   value_bits_i,
  output logic                          done_o,
  output logic [63:0]                   result_bits_o,
  output logic                          overflow_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtcf_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dtcf_pkg::*;

  logic [3:0] exp_width_q;
  logic [5:0] man_width_q;
  fmt_t       fmt;
  logic       v1, v2;
  norm_t      norm;
  plan_t      plan;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_width_q <= ExpWidthReset;
      man_width_q <= ManWidthReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrExpWidth) begin
        exp_width_q <= pwdata[3:0];
      end else if (paddr == AddrManWidth) begin
        man_width_q <= pwdata[5:0];
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == AddrExpWidth) begin
      prdata = {28'd0, exp_width_q};
    end else if (paddr == AddrManWidth) begin
      prdata = {26'd0, man_width_q};
    end
  end

  always_comb begin
    fmt.e = (exp_width_q < 4'd2) ? 4'd2 : ((exp_width_q > 4'd11) ? 4'd11 : exp_width_q);
    fmt.m = (man_width_q < 6'd1) ? 6'd1 : ((man_width_q > 6'd52) ? 6'd52 : man_width_q);
  end

  dtcf_unpack u_unpack (
    .clk_i, .rst_ni, .valid_i(start), .value_bits_i, .valid_o(v1), .norm_o(norm)
  );

  dtcf_plan u_plan (
    .clk_i, .rst_ni, .valid_i(v1), .norm_i(norm), .fmt_i(fmt), .valid_o(v2), .plan_o(plan)
  );

  dtcf_round u_round (
    .clk_i, .rst_ni, .valid_i(v2), .plan_i(plan), .fmt_i(fmt),
    .valid_o(done_o), .result_bits_o, .overflow_o
  );
endmodule

### rtl/dtcf_unpack.sv
// First stage: splits the double, normalizes the significand and registers the result.
module dtcf_unpack (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [63:0]          value_bits_i,
  output logic                 valid_o,
  output dtcf_pkg::norm_t      norm_o
);
  import dtcf_pkg::*;

  logic        valid_q;
  norm_t       norm_q, norm_d;
  logic [10:0] ex;
  logic [51:0] frac;
  logic [52:0] sig;
  logic [5:0]  lz;

  assign ex   = value_bits_i[62:52];
  assign frac = value_bits_i[51:0];
  assign sig  = (ex == 11'd0) ? {1'b0, frac} : {1'b1, frac};

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (sig[i]) begin
        lz = 6'(52 - i);
      end
    end
  end

  always_comb begin
    norm_d.sign    = value_bits_i[63];
    norm_d.special = (ex == 11'h7FF);
    norm_d.zero    = (sig == 53'd0);
    norm_d.sig     = sig << lz;
    // Unbiased exponent of the leading one, offset by 2048.
    if (ex == 11'd0) begin
      norm_d.exp_top = 13'(2048 - 1022) - 13'(lz);
    end else begin
      norm_d.exp_top = 13'(2048 - 1023) + 13'(ex);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q <= norm_d;
  end

  assign valid_o = valid_q;
  assign norm_o  = norm_q;
endmodule

### rtl/dtcf_plan.sv
// Second stage: picks normal or subnormal handling and the rounding shift.
module dtcf_plan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  dtcf_pkg::norm_t  norm_i,
  input  dtcf_pkg::fmt_t   fmt_i,
  output logic             valid_o,
  output dtcf_pkg::plan_t  plan_o
);
  import dtcf_pkg::*;

  logic        valid_q;
  plan_t       plan_q, plan_d;
  logic [12:0] emin_top;
  logic [12:0] gap;

  // Smallest normal exponent is 2 - 2^(e-1), offset by 2048.
  assign emin_top = 13'd2050 - (13'd1 << (fmt_i.e - 4'd1));
  assign gap      = emin_top - norm_i.exp_top;

  always_comb begin
    plan_d.sign    = norm_i.sign;
    plan_d.special = norm_i.special;
    plan_d.zero    = norm_i.zero;
    plan_d.exp_top = norm_i.exp_top;
    plan_d.sig     = norm_i.sig;
    plan_d.subn    = ($signed(norm_i.exp_top) < $signed(emin_top));
    if (plan_d.subn) begin
      plan_d.shift = (gap > 13'd70) ? 7'd70 : 7'(7'd52 - 7'(fmt_i.m) + 7'(gap));
    end else begin
      plan_d.shift = 7'(7'd52 - 7'(fmt_i.m));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    plan_q <= plan_d;
  end

  assign valid_o = valid_q;
  assign plan_o  = plan_q;
endmodule

### rtl/dtcf_round.sv
// Third and fourth stages: round to nearest even, then pack the target encoding.
module dtcf_round (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  dtcf_pkg::plan_t  plan_i,
  input  dtcf_pkg::fmt_t   fmt_i,
  output logic             valid_o,
  output logic [63:0]      result_bits_o,
  output logic             overflow_o
);
  import dtcf_pkg::*;

  logic        valid_q, valid2_q;
  logic [53:0] q_q, q_d;
  logic        sign_q, special_q, zero_q, subn_q;
  logic [12:0] exp_q;
  logic [52:0] kept, rem, half;
  logic        up;
  logic [63:0] res_q, res_d;
  logic        ovf_q, ovf_d;

  always_comb begin
    if (plan_i.shift >= 7'd54) begin
      kept = 53'd0;
      rem  = 53'd0;
      half = 53'd1;
      up   = 1'b0;
    end else begin
      kept = plan_i.sig >> plan_i.shift;
      rem  = plan_i.sig & ((53'd1 << plan_i.shift) - 53'd1);
      half = (plan_i.shift == 7'd0) ? 53'd0 : (53'd1 << (plan_i.shift - 7'd1));
      up   = (plan_i.shift != 7'd0) && ((rem > half) || (rem == half && kept[0]));
    end
    q_d = {1'b0, kept} + 54'(up);
  end

  always_ff @(posedge clk_i) begin
    q_q       <= q_d;
    sign_q    <= plan_i.sign;
    special_q <= plan_i.special;
    zero_q    <= plan_i.zero;
    subn_q    <= plan_i.subn;
    exp_q     <= plan_i.exp_top;
    res_q     <= res_d;
    ovf_q     <= ovf_d;
  end

  logic [63:0] sign_field, inf_pat, man_mask;
  logic [53:0] q_adj;
  logic [12:0] biased, emax;

  always_comb begin
    sign_field = 64'(sign_q) << (fmt_i.e + fmt_i.m);
    emax       = (13'd1 << fmt_i.e) - 13'd1;
    inf_pat    = sign_field | (64'(emax) << fmt_i.m);
    man_mask   = (64'd1 << fmt_i.m) - 64'd1;
    q_adj      = q_q;
    biased     = exp_q - 13'd2049 + (13'd1 << (fmt_i.e - 4'd1));
    if ((q_q >> (fmt_i.m + 6'd1)) != 54'd0) begin
      q_adj  = q_q >> 1;
      biased = biased + 13'd1;
    end
    ovf_d = 1'b0;
    if (special_q) begin
      res_d = inf_pat;
      ovf_d = 1'b1;
    end else if (zero_q) begin
      res_d = sign_field;
    end else if (subn_q) begin
      res_d = sign_field | 64'(q_q);
    end else if ($signed(biased) >= $signed(emax)) begin
      res_d = inf_pat;
      ovf_d = 1'b1;
    end else begin
      res_d = sign_field | (64'(biased) << fmt_i.m) | (64'(q_adj) & man_mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid_q  <= valid_i;
      valid2_q <= valid_q;
    end
  end

  assign valid_o       = valid2_q;
  assign result_bits_o = res_q;
  assign overflow_o    = ovf_q;
endmodule

### bench/tb_double_to_custom_float_top.sv
// Self-checking testbench for the double to custom float converter top level.
`timescale 1ns / 100ps

module tb_double_to_custom_float_top;
  import dtcf_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] value_bits_i = '0;
  logic        done_o;
  logic [63:0] result_bits_o;
  logic        overflow_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  typedef struct packed {
    logic [63:0] bits;
    logic        ovf;
  } conv_t;

  conv_t       conv_q[$];
  logic [3:0]  cur_exp;
  logic [5:0]  cur_man;
  int unsigned fail_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  double_to_custom_float_top u_top (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("double_to_custom_float_top test failed");
      $finish;
    end
  end

  function automatic logic [63:0] round_even(logic [63:0] sig, int s);
    logic [63:0] q, rem, half;
    if (s > 60) return 64'd0;
    q = sig >> s;
    rem = sig & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  function automatic conv_t convert(logic [63:0] x, logic [3:0] ew, logic [5:0] mw);
    conv_t r;
    int e, m, ex, bexp, k, bias, emin, s, biased, emax, tb;
    logic [63:0] frac, sig, q, sfield, infp;
    e = ew; m = mw;
    if (e < 2) e = 2;
    if (e > 11) e = 11;
    if (m < 1) m = 1;
    if (m > 52) m = 52;
    ex = x[62:52];
    frac = {12'd0, x[51:0]};
    sfield = {63'd0, x[63]} << (e + m);
    emax = (1 << e) - 1;
    infp = sfield | (64'(emax) << m);
    bias = (1 << (e - 1)) - 1;
    emin = 1 - bias;
    r.ovf = 1'b0;
    if (ex == 2047) begin
      r.bits = infp; r.ovf = 1'b1; return r;
    end
    if (ex == 0 && frac == 0) begin
      r.bits = sfield; return r;
    end
    if (ex == 0) begin
      sig = frac; bexp = -1074;
    end else begin
      sig = frac | (64'd1 << 52); bexp = ex - 1075;
    end
    tb = 0;
    for (int i = 0; i < 64; i++) if (sig[i]) tb = i;
    k = bexp + tb;
    if (k >= emin) begin
      s = k - m - bexp;
      q = (s <= 0) ? (sig << (-s)) : round_even(sig, s);
      if ((q >> (m + 1)) != 0) begin
        q = q >> 1; k++;
      end
      biased = k + bias;
      if (biased >= emax) begin
        r.bits = infp; r.ovf = 1'b1; return r;
      end
      r.bits = sfield | (64'(biased) << m) | (q & ((64'd1 << m) - 64'd1));
      return r;
    end
    s = emin - m - bexp;
    q = (s <= 0) ? (sig << (-s)) : round_even(sig, s);
    r.bits = sfield | q;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (done_o) begin
      if (conv_q.size() == 0) begin
        $error("unexpected word: result_bits %h", result_bits_o);
        fail_count++;
      end else begin
        conv_t exp_w;
        exp_w = conv_q.pop_front();
        if (result_bits_o !== exp_w.bits) begin
          $error("result_bits expected %h actual %h", exp_w.bits, result_bits_o);
          fail_count++;
        end
        if (overflow_o !== exp_w.ovf) begin
          $error("overflow expected %b actual %b", exp_w.ovf, overflow_o);
          fail_count++;
        end
        words_checked++;
      end
    end
  end

  task automatic send_word(logic [63:0] v);
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    value_bits_i <= v;
    do @(posedge clk_i); while (busy);
    conv_q.push_back(convert(v, cur_exp, cur_man));
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (conv_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [AddrWidth-1:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrExpWidth) cur_exp = data[3:0];
    else cur_man = data[5:0];
    @(posedge clk_i);
  endtask

  task automatic set_format(logic [3:0] ew, logic [5:0] mw);
    drain();
    write_reg(AddrExpWidth, {28'd0, ew});
    write_reg(AddrManWidth, {26'd0, mw});
  endtask

  function automatic logic [63:0] rand_double();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v[62:52] = 11'd1023 + 11'($urandom_range(40)) - 11'd20;
      1: v[62:52] = 11'd1023 + 11'($urandom_range(2100)) - 11'd1050;
      2: v[62:52] = 11'($urandom_range(3) * 682);
      3: v[30:0] = 31'($urandom_range(1) ? 0 : 31'h7fffffff);
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    logic [63:0] pats[$];
    pats = '{64'h0, 64'h8000000000000000, 64'h3ff0000000000000, 64'hbff0000000000000,
             64'h7ff0000000000000, 64'hfff0000000000000, 64'h7ff8000000000001,
             64'h0000000000000001, 64'h000fffffffffffff, 64'h7fefffffffffffff,
             64'h47efffffe0000000, 64'h47efffff00000000, 64'h3810000000000000,
             64'h380fffffffffffff, 64'h36a0000000000000, 64'h3690000000000000,
             64'h36a8000000000000, 64'h3ff0000010000000, 64'h3ff0000030000000,
             64'hffffffffffffffff, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa};
    foreach (pats[i]) send_word(pats[i]);
  endtask

  task automatic test_formats();
    logic [3:0] ews[$];
    logic [5:0] mws[$];
    ews = '{4'd2, 4'd11, 4'd0, 4'd15, 4'd5, 4'd11, 4'd2};
    mws = '{6'd1, 6'd52, 6'd0, 6'd63, 6'd10, 6'd1, 6'd52};
    foreach (ews[i]) begin
      set_format(ews[i], mws[i]);
      test_directed();
    end
  endtask

  task automatic test_random();
    for (int n = 0; n < 330; n++) begin
      if (n % 50 == 0)
        set_format(4'($urandom_range(15)), 6'($urandom_range(63)));
      calm = (n >= 100 && n < 180);
      send_word(rand_double());
    end
    calm = 1'b0;
  endtask

  initial begin
    cur_exp = ExpWidthReset;
    cur_man = ManWidthReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_formats();
    test_random();
    drain();
    $display("Sent %0d words and checked %0d results across many formats,",
             words_sent, words_checked);
    $display("including specials, subnormals, rounding ties and overflow.");
    if (fail_count == 0 && conv_q.size() == 0) begin
      $display("double_to_custom_float_top test passed");
    end else begin
      $display("double_to_custom_float_top test failed");
    end
    $finish;
  end
endmodule

### files.f
rtl/dtcf_pkg.sv
rtl/dtcf_unpack.sv
rtl/dtcf_plan.sv
rtl/dtcf_round.sv
rtl/double_to_custom_float_top.sv
bench/tb_double_to_custom_float_top.sv
